/* rtl/core/afp_pkg.sv */
package afp_pkg;

    localparam int DIM_BITS  = 16;
    localparam int PROD_BITS = 2 * DIM_BITS;
    localparam int CFG_BITS  = 2;

    // registers from request to result: input reg, multiply, compare/select, one cell per bit, output reg
    localparam int LATENCY = DIM_BITS + 4;

    localparam logic [CFG_BITS-1:0] CFG_CANVAS_W = CFG_BITS'(0);
    localparam logic [CFG_BITS-1:0] CFG_CANVAS_H = CFG_BITS'(1);

    localparam logic [DIM_BITS-1:0] EVEN_MASK = {{(DIM_BITS-1){1'b1}}, 1'b0};

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_CANVAS = 2'd2,
        ST_SMALL  = 2'd3
    } status_t;

    // one beat travelling down the divider chain
    typedef struct packed {
        logic [DIM_BITS-1:0] rem;
        logic [DIM_BITS-1:0] low;
        logic [DIM_BITS-1:0] quot;
        logic [DIM_BITS-1:0] divisor;
        status_t             status;
        logic                wide;
        logic [DIM_BITS-1:0] cw;
        logic [DIM_BITS-1:0] ch;
    } div_beat_t;

endpackage

/* rtl/core/afp_div_cell.sv */
module afp_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  afp_pkg::div_beat_t in_beat,
    output logic              out_valid,
    output afp_pkg::div_beat_t out_beat
);
    import afp_pkg::*;

    logic                valid_reg;
    div_beat_t           beat_reg;
    div_beat_t           beat_next;
    logic [DIM_BITS:0]   trial;
    logic [DIM_BITS:0]   diff;
    logic                ge;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {in_beat.rem, in_beat.low[DIM_BITS-1]};
        ge        = (trial >= {1'b0, in_beat.divisor});
        diff      = trial - {1'b0, in_beat.divisor};
        beat_next = in_beat;
        beat_next.rem  = ge ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
        beat_next.low  = {in_beat.low[DIM_BITS-2:0], 1'b0};
        beat_next.quot = {in_beat.quot[DIM_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

/* rtl/core/afp_div_chain.sv */
module afp_div_chain (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  afp_pkg::div_beat_t in_beat,
    output logic              out_valid,
    output afp_pkg::div_beat_t out_beat
);
    import afp_pkg::*;

    logic      link_valid [0:DIM_BITS];
    div_beat_t link_beat  [0:DIM_BITS];

    assign link_valid[0] = in_valid;
    assign link_beat[0]  = in_beat;

    // one cell per quotient bit, MSB first
    for (genvar i = 0; i < DIM_BITS; i++)
    begin : g_cell
        afp_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_beat   (link_beat[i]),
            .out_valid (link_valid[i+1]),
            .out_beat  (link_beat[i+1])
        );
    end

    assign out_valid = link_valid[DIM_BITS];
    assign out_beat  = link_beat[DIM_BITS];

endmodule

/* rtl/core/aspect_fit_placement.sv */
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-----------------------------------------
// request  | in        | start && !busy     | source_width, source_height
// result   | out       | done (1 cycle)     | status, offset_x/y, fit_width/height
// config   | in        | cfg_valid&cfg_ready| cfg_index, cfg_data
//
// One request per cycle; busy is never raised. A request passes through the input reg,
// the multiplier stage, compare/select, one divider cell per quotient bit and the output
// reg before its done strobe. The divider chain sets the pipeline depth. rst_n clears
// all valid flags and sets the canvas to 1920x1080.
// Results cannot be held off: done is a single-cycle strobe.
module aspect_fit_placement (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [afp_pkg::DIM_BITS-1:0]     source_width,
    input  logic [afp_pkg::DIM_BITS-1:0]     source_height,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [afp_pkg::DIM_BITS-1:0]     offset_x,
    output logic [afp_pkg::DIM_BITS-1:0]     offset_y,
    output logic [afp_pkg::DIM_BITS-1:0]     fit_width,
    output logic [afp_pkg::DIM_BITS-1:0]     fit_height,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [afp_pkg::CFG_BITS-1:0]     cfg_index,
    input  logic [afp_pkg::DIM_BITS-1:0]     cfg_data
);
    import afp_pkg::*;

    logic [DIM_BITS-1:0]  canvas_w_reg;
    logic [DIM_BITS-1:0]  canvas_h_reg;

    logic                 s1_valid_reg;
    logic [DIM_BITS-1:0]  s1_sw_reg;
    logic [DIM_BITS-1:0]  s1_sh_reg;
    logic [DIM_BITS-1:0]  s1_cw_reg;
    logic [DIM_BITS-1:0]  s1_ch_reg;

    logic                 s2_valid_reg;
    logic [PROD_BITS-1:0] s2_prod_a_reg;
    logic [PROD_BITS-1:0] s2_prod_b_reg;
    logic [DIM_BITS-1:0]  s2_sw_reg;
    logic [DIM_BITS-1:0]  s2_sh_reg;
    logic [DIM_BITS-1:0]  s2_cw_reg;
    logic [DIM_BITS-1:0]  s2_ch_reg;
    status_t              s2_status_reg;
    status_t              s2_status_next;

    logic                 s3_valid_reg;
    div_beat_t            s3_beat_reg;
    div_beat_t            s3_beat_next;
    logic                 wide;
    logic [PROD_BITS-1:0] dividend;

    logic                 chain_valid;
    div_beat_t            chain_beat;

    logic                 done_reg;
    status_t              status_reg;
    status_t              status_next;
    logic [DIM_BITS-1:0]  offset_x_reg;
    logic [DIM_BITS-1:0]  offset_x_next;
    logic [DIM_BITS-1:0]  offset_y_reg;
    logic [DIM_BITS-1:0]  offset_y_next;
    logic [DIM_BITS-1:0]  scaled_w_reg;
    logic [DIM_BITS-1:0]  scaled_w_next;
    logic [DIM_BITS-1:0]  scaled_h_reg;
    logic [DIM_BITS-1:0]  scaled_h_next;
    logic [DIM_BITS-1:0]  q_even;
    logic [DIM_BITS-1:0]  fw;
    logic [DIM_BITS-1:0]  fh;
    logic [DIM_BITS-1:0]  border_x;
    logic [DIM_BITS-1:0]  border_y;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_w_reg <= DIM_BITS'(1920);
            canvas_h_reg <= DIM_BITS'(1080);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_CANVAS_W)
            begin
                canvas_w_reg <= cfg_data;
            end
            else if (cfg_index == CFG_CANVAS_H)
            begin
                canvas_h_reg <= cfg_data;
            end
        end
    end

    // ---------------- stage 1: capture request and canvas
    always_ff @(posedge clk)
    begin
        s1_sw_reg <= source_width;
        s1_sh_reg <= source_height;
        s1_cw_reg <= canvas_w_reg;
        s1_ch_reg <= canvas_h_reg;
    end

    // ---------------- stage 2: cross products, early status
    always_comb
    begin
        if (s1_sw_reg == '0 || s1_sh_reg == '0)
        begin
            s2_status_next = ST_EMPTY;
        end
        else if (s1_cw_reg == '0 || s1_ch_reg == '0 || s1_cw_reg[0] || s1_ch_reg[0])
        begin
            s2_status_next = ST_CANVAS;
        end
        else
        begin
            s2_status_next = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_prod_a_reg <= PROD_BITS'(s1_sw_reg) * PROD_BITS'(s1_ch_reg);
        s2_prod_b_reg <= PROD_BITS'(s1_cw_reg) * PROD_BITS'(s1_sh_reg);
        s2_sw_reg     <= s1_sw_reg;
        s2_sh_reg     <= s1_sh_reg;
        s2_cw_reg     <= s1_cw_reg;
        s2_ch_reg     <= s1_ch_reg;
        s2_status_reg <= s2_status_next;
    end

    // ---------------- stage 3: pick the constrained axis, load the divider
    // with a nonzero divisor the quotient fits DIM_BITS, so the dividend high half is below the divisor
    always_comb
    begin
        wide     = (s2_prod_a_reg >= s2_prod_b_reg);
        dividend = wide ? s2_prod_b_reg : s2_prod_a_reg;
        s3_beat_next.rem     = dividend[PROD_BITS-1:DIM_BITS];
        s3_beat_next.low     = dividend[DIM_BITS-1:0];
        s3_beat_next.quot    = '0;
        s3_beat_next.divisor = wide ? s2_sw_reg : s2_sh_reg;
        s3_beat_next.status  = s2_status_reg;
        s3_beat_next.wide    = wide;
        s3_beat_next.cw      = s2_cw_reg;
        s3_beat_next.ch      = s2_ch_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_beat_reg <= s3_beat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= chain_valid;
        end
    end

    afp_div_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_beat   (s3_beat_reg),
        .out_valid (chain_valid),
        .out_beat  (chain_beat)
    );

    // ---------------- final stage: even floor, borders, status
    always_comb
    begin
        q_even   = chain_beat.quot & EVEN_MASK;
        fw       = chain_beat.wide ? chain_beat.cw : q_even;
        fh       = chain_beat.wide ? q_even : chain_beat.ch;
        border_x = chain_beat.cw - fw;
        border_y = chain_beat.ch - fh;

        if (chain_beat.status != ST_OK)
        begin
            status_next = chain_beat.status;
        end
        else if (q_even == '0)
        begin
            status_next = ST_SMALL;
        end
        else
        begin
            status_next = ST_OK;
        end

        if (status_next == ST_OK)
        begin
            offset_x_next = (border_x >> 1) & EVEN_MASK;
            offset_y_next = (border_y >> 1) & EVEN_MASK;
            scaled_w_next = fw;
            scaled_h_next = fh;
        end
        else
        begin
            offset_x_next = '0;
            offset_y_next = '0;
            scaled_w_next = '0;
            scaled_h_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        offset_x_reg <= offset_x_next;
        offset_y_reg <= offset_y_next;
        scaled_w_reg <= scaled_w_next;
        scaled_h_reg <= scaled_h_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign offset_x   = offset_x_reg;
    assign offset_y   = offset_y_reg;
    assign fit_width  = scaled_w_reg;
    assign fit_height = scaled_h_reg;

`ifndef SYNTH
    a_chain_depth: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid |-> $past(s3_valid_reg, DIM_BITS))
        else $error("divider chain valid does not match its depth");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |->
            offset_x == '0 && offset_y == '0 && fit_width == '0 && fit_height == '0)
        else $error("error result carries nonzero fields");

    a_ok_even: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_OK |->
            !fit_width[0] && !fit_height[0] && !offset_x[0] && !offset_y[0])
        else $error("odd extent or offset in ok result");

    a_fits_x: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_OK |->
            ({1'b0, offset_x} + {1'b0, fit_width}) <= {1'b0, canvas_w_reg})
        else $error("placed picture exceeds canvas width");

    a_fits_y: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_OK |->
            ({1'b0, offset_y} + {1'b0, fit_height}) <= {1'b0, canvas_h_reg})
        else $error("placed picture exceeds canvas height");
`endif

endmodule
